// ===== hdl/assert_macros.svh =====
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sonl6_pkg.sv =====
// ---------------------------------------------------------------------------
// sonl6_pkg
// shared types and constants for the second-order nonlinearity core
// ---------------------------------------------------------------------------
package sonl6_pkg;

	localparam int unsigned NUM_FORMS = 1024;
	localparam int unsigned FORM_W    = 10;
	localparam int unsigned NL_W      = 6;

	typedef logic [FORM_W-1:0] form_t;
	typedef logic [NL_W-1:0]   nl_t;
	typedef logic [31:0]       half_t;
	typedef logic signed [6:0] wcoef_t;
	typedef wcoef_t            wvec_t [32];

	localparam logic [4:0] MONO_MASK [10] = '{
		5'd24, 5'd20, 5'd18, 5'd17, 5'd12, 5'd10, 5'd9, 5'd6, 5'd5, 5'd3
	};

	// truth table of quadratic form over 32 points
	function automatic half_t quad_table(input form_t form);
		half_t q;
		logic  v;
		q = '0;
		for (int x = 0; x < 32; x++) begin
			v = 1'b0;
			for (int j = 0; j < 10; j++) begin
				if (form[9-j] && ((5'(x) & MONO_MASK[j]) == MONO_MASK[j])) begin
					v = ~v;
				end
			end
			q[x] = v;
		end
		return q;
	endfunction

	// one butterfly layer of the walsh transform
	function automatic wvec_t fwht_layer(input int unsigned len, input wvec_t w);
		wvec_t r;
		r = w;
		for (int i = 0; i < 32; i++) begin
			if ((i & len) == 0) begin
				r[i] = w[i] + w[i + len];
				r[i + len] = w[i] - w[i + len];
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/second_order_nonlinearity_6var_core.sv =====
// the sweep of all 1024 quadratic forms feeds 6 register stages (s1 to s6) to the result
// in_stall is held while a sweep is busy, so a new truth table waits for the last result
// (one quadratic form per cycle into two 32-point walsh pipelines while no result is stalled)
// reset: arst_n clears the sweep counter, stage valids and the output register
// ---------------------------------------------------------------------------
// second_order_nonlinearity_6var_core
// distance of a 6-variable function to RM(2,6) via quadratic form sweep
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module second_order_nonlinearity_6var_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [63:0]          truth_table,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [5:0]           second_order_nl
);
	import sonl6_pkg::*;

	logic        busy_q;
	logic        fill_done_q;
	form_t       form_q;
	half_t       even_q;
	half_t       odd_q;
	logic        adv;

	// stage registers
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic        last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	half_t       e_s1, o_s1;
	wcoef_t      we_s2 [32], wo_s2 [32];
	wcoef_t      we_s3 [32], wo_s3 [32];
	wcoef_t      we_s4 [32], wo_s4 [32];
	logic [5:0]  me_s5, mo_s5;
	logic [5:0]  sum_s6;
	logic [5:0]  best_q;
	logic        res_valid_q;
	nl_t         res_q;

	// sweep advances unless a held result is stalled at the output
	assign adv      = !(res_valid_q && out_stall);
	assign in_stall = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			form_q <= '0;
			fill_done_q <= 1'b0;
		end else if (!busy_q) begin
			if (in_valid && !in_stall) begin
				busy_q <= 1'b1;
				form_q <= '0;
				fill_done_q <= 1'b0;
			end
		end else if (adv) begin
			if (!fill_done_q) begin
				form_q <= form_q + 1'b1;
				if (form_q == form_t'(NUM_FORMS - 1)) begin
					fill_done_q <= 1'b1;
				end
			end
			if (v_s6 && last_s6) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && in_valid && !in_stall) begin
			for (int i = 0; i < 32; i++) begin
				even_q[i] <= truth_table[2*i];
				odd_q[i]  <= truth_table[2*i+1];
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
		end else if (adv) begin
			v_s1 <= busy_q && !fill_done_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		wvec_t te;
		wvec_t to;
		logic [6:0] mge [32];
		logic [6:0] mgo [32];
		if (adv) begin
			// s1: apply quadratic form
			e_s1    <= even_q ^ quad_table(form_q);
			o_s1    <= odd_q ^ quad_table(form_q);
			last_s1 <= (form_q == form_t'(NUM_FORMS - 1));
			// s2: map and two layers
			for (int i = 0; i < 32; i++) begin
				te[i] = e_s1[i] ? -7'sd1 : 7'sd1;
				to[i] = o_s1[i] ? -7'sd1 : 7'sd1;
			end
			te = fwht_layer(1, te);
			te = fwht_layer(2, te);
			to = fwht_layer(1, to);
			to = fwht_layer(2, to);
			we_s2 <= te;
			wo_s2 <= to;
			last_s2 <= last_s1;
			// s3: two layers
			te = we_s2;
			to = wo_s2;
			te = fwht_layer(4, te);
			te = fwht_layer(8, te);
			to = fwht_layer(4, to);
			to = fwht_layer(8, to);
			we_s3 <= te;
			wo_s3 <= to;
			last_s3 <= last_s2;
			// s4: last layer
			te = we_s3;
			to = wo_s3;
			te = fwht_layer(16, te);
			to = fwht_layer(16, to);
			we_s4 <= te;
			wo_s4 <= to;
			last_s4 <= last_s3;
			// s5: max magnitude, compare tree
			for (int i = 0; i < 32; i++) begin
				mge[i] = we_s4[i][6] ? 7'(-we_s4[i]) : 7'(we_s4[i]);
				mgo[i] = wo_s4[i][6] ? 7'(-wo_s4[i]) : 7'(wo_s4[i]);
			end
			for (int s = 16; s > 0; s = s >> 1) begin
				for (int i = 0; i < s; i++) begin
					if (mge[i + s] > mge[i]) mge[i] = mge[i + s];
					if (mgo[i + s] > mgo[i]) mgo[i] = mgo[i + s];
				end
			end
			me_s5 <= 6'(mge[0] >> 1);
			mo_s5 <= 6'(mgo[0] >> 1);
			last_s5 <= last_s4;
			// s6: sum of nonlinearities
			sum_s6  <= 6'd32 - me_s5 - mo_s5;
			last_s6 <= last_s5;
		end
	end

	// running minimum and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= 6'd63;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && !out_stall) begin
				res_valid_q <= 1'b0;
			end
			if (adv && v_s6) begin
				if (last_s6) begin
					res_q       <= (sum_s6 < best_q) ? sum_s6 : best_q;
					res_valid_q <= 1'b1;
					best_q      <= 6'd63;
				end else if (sum_s6 < best_q) begin
					best_q <= sum_s6;
				end
			end
		end
	end

	assign out_valid       = res_valid_q;
	assign second_order_nl = res_q;

	`ASSERT_CLK(a_no_accept_busy, clk, arst_n, !(busy_q && in_valid && !in_stall),
		"item accepted while sweep busy")
	`ASSERT_CLK(a_result_range, clk, arst_n, !res_valid_q || (res_q <= 6'd32),
		"result out of range")
	`ASSERT_NEXT(a_last_done, clk, arst_n, adv && v_s6 && last_s6, res_valid_q && !busy_q,
		"last candidate did not produce a result")

endmodule

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// checks the second-order nonlinearity core against an in-bench predictor:
// directed and random truth tables, near-quadratic functions, random idling
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sonl6_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS   = 560;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] truth_table;
	logic        out_valid;
	logic        out_stall;
	nl_t         second_order_nl;

	logic [63:0] stim_q [$];
	nl_t         expected_nl_q [$];
	half_t       form_table [NUM_FORMS];
	int          sent;
	int          mismatches;
	int          idle_cycles;
	bit          item_taken;
	bit          stim_done;

	second_order_nonlinearity_6var_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.truth_table     (truth_table),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.second_order_nl (second_order_nl)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int half_linear_nl(input half_t bits);
		int w [32];
		int a;
		int b;
		int peak;
		peak = 0;
		for (int i = 0; i < 32; i++) w[i] = bits[i] ? -1 : 1;
		for (int len = 1; len < 32; len = len * 2) begin
			for (int i = 0; i < 32; i++) begin
				if ((i & len) == 0) begin
					a = w[i];
					b = w[i + len];
					w[i] = a + b;
					w[i + len] = a - b;
				end
			end
		end
		for (int i = 0; i < 32; i++) begin
			a = (w[i] < 0) ? -w[i] : w[i];
			if (a > peak) peak = a;
		end
		return 16 - peak / 2;
	endfunction

	function automatic nl_t rm2_distance(input logic [63:0] tt);
		half_t even_h;
		half_t odd_h;
		int    best;
		int    sum;
		best = 64;
		for (int i = 0; i < 32; i++) begin
			even_h[i] = tt[2*i];
			odd_h[i]  = tt[2*i+1];
		end
		for (int f = 0; f < NUM_FORMS; f++) begin
			sum = half_linear_nl(even_h ^ form_table[f]) + half_linear_nl(odd_h ^ form_table[f]);
			if (sum < best) best = sum;
		end
		return nl_t'(best);
	endfunction

	// random quadratic in 6 variables plus a few flipped points
	function automatic logic [63:0] near_quadratic(input int flips);
		logic [14:0] pairs;
		logic [6:0]  lin;
		logic [63:0] tt;
		logic        v;
		int          p;
		pairs = 15'($urandom);
		lin   = 7'($urandom);
		for (int n = 0; n < 64; n++) begin
			v = lin[6];
			for (int i = 0; i < 6; i++) v ^= lin[i] & n[i];
			p = 0;
			for (int i = 0; i < 6; i++) begin
				for (int j = i + 1; j < 6; j++) begin
					v ^= pairs[p] & n[i] & n[j];
					p++;
				end
			end
			tt[n] = v;
		end
		for (int k = 0; k < flips; k++) tt[$urandom_range(63)] ^= 1'b1;
		return tt;
	endfunction

	function automatic int sender_idle_pct(input int n);
		case ((n / 70) % 4)
			1: return 66;
			3: return 9;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct(input int n);
		case ((n / 70) % 4)
			2: return 66;
			3: return 9;
			default: return 0;
		endcase
	endfunction

	// acceptance, prediction, checking, watchdog
	always @(posedge clk) begin
		item_taken = arst_n && in_valid && !in_stall;
		if (item_taken) begin
			expected_nl_q.push_back(rm2_distance(truth_table));
		end
		if (arst_n && out_valid && !out_stall) begin
			idle_cycles = 0;
			if (expected_nl_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: second_order_nl=%0d", second_order_nl);
			end else begin
				if (second_order_nl !== expected_nl_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("second_order_nl mismatch: expected %0d actual %0d",
							expected_nl_q[0], second_order_nl);
				end
				void'(expected_nl_q.pop_front());
			end
		end else if (item_taken) begin
			idle_cycles = 0;
		end else if (arst_n && (!stim_done || expected_nl_q.size() != 0)) begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || item_taken) begin
				if (stim_q.size() != 0 && !(sent == 40 && expected_nl_q.size() != 0)
						&& $urandom_range(99) >= sender_idle_pct(sent)) begin
					truth_table <= stim_q.pop_front();
					in_valid    <= 1'b1;
					sent++;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < receiver_stall_pct(sent));
		end
	end

	initial begin
		in_valid    = 1'b0;
		out_stall   = 1'b0;
		truth_table = '0;
		arst_n      = 1'b0;
		sent        = 0;
		mismatches  = 0;
		idle_cycles = 0;
		item_taken  = 1'b0;
		stim_done   = 1'b0;

		for (int f = 0; f < NUM_FORMS; f++) begin
			for (int x = 0; x < 32; x++) begin
				form_table[f][x] = 1'b0;
				for (int j = 0; j < 10; j++) begin
					if (f[9-j] && ((x & MONO_MASK[j]) == MONO_MASK[j]))
						form_table[f][x] = ~form_table[f][x];
				end
			end
		end

		stim_q.push_back(64'h0);
		stim_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
		stim_q.push_back(64'h5555_5555_5555_5555);
		stim_q.push_back(64'hAAAA_AAAA_AAAA_AAAA);
		stim_q.push_back(64'h0000_0000_0000_0001);
		stim_q.push_back(64'h8000_0000_0000_0000);
		stim_q.push_back(64'hFFFF_FFFF_FFFF_FFFE);
		stim_q.push_back(64'h0000_0000_FFFF_FFFF);
		stim_q.push_back(64'h0F0F_0F0F_0F0F_0F0F);
		stim_q.push_back(64'h3333_3333_CCCC_CCCC);
		stim_q.push_back(64'h8000_0000_0000_0001);
		stim_q.push_back(64'h6996_9669_9669_6996);
		stim_q.push_back(64'h0000_0000_0000_8000);
		for (int k = 0; k < 4; k++) stim_q.push_back(near_quadratic(0));
		for (int k = 0; k < 4; k++) stim_q.push_back(near_quadratic(1));
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 2 == 0) stim_q.push_back({$urandom, $urandom});
			else stim_q.push_back(near_quadratic($urandom_range(12)));
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (stim_q.size() == 0 && !in_valid);
		stim_done = 1'b1;
		wait (expected_nl_q.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_nl_q.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sonl6_pkg.sv
hdl/second_order_nonlinearity_6var_core.sv
tb/sv/tb.sv
